@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define USBB_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("usbb assertion failed");

// Next-cycle implication, disabled during reset.
`define USBB_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("usbb assertion failed");

// Next-cycle implication that is also checked while reset is high.
`define USBB_ASSERT_NXT_ALWAYS(lbl, c, a, b) \
  lbl: assert property (@(posedge c) (a) |=> (b)) \
    else $error("usbb assertion failed");

`endif

@@ src/usbb_pkg.sv @@
// ----------------------------------------------------------------------------
// usbb_pkg
// Types, codes and constants of the USB serial bridge buffer control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package usbb_pkg;

  localparam int DEF_TX_DEPTH     = 16;
  localparam int DEF_RX_DEPTH     = 16;
  localparam int DEF_BUS_CLOCK_HZ = 24000000;

  localparam int CMD_W    = 3;
  localparam int ACT_W    = 2;
  localparam int DIV_W    = 14;
  localparam int RXIDX_W  = 4;
  localparam int RXCNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TX_LOAD    = 3'd0,
    CMD_TX_READY   = 3'd1,
    CMD_RX_BYTE    = 3'd2,
    CMD_RX_SWAP    = 3'd3,
    CMD_LINE_ERROR = 3'd4,
    CMD_GET_STATE  = 3'd5,
    CMD_SEND_BREAK = 3'd6,
    CMD_SET_CODING = 3'd7
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE      = 2'd0,
    ACT_SEND_BYTE = 2'd1,
    ACT_BREAK     = 2'd2,
    ACT_IRQ_OFF   = 2'd3
  } tx_action_t;

  // Serial state / status bits
  localparam logic [7:0] ST_CHANGE  = 8'h80;
  localparam logic [7:0] ST_BASE    = 8'h03;
  localparam logic [7:0] ST_FRAMING = 8'h10;
  localparam logic [7:0] ST_PARITY  = 8'h20;
  localparam logic [7:0] ST_OVERRUN = 8'h40;
  localparam logic [7:0] US_FE      = 8'h02;
  localparam logic [7:0] US_OR      = 8'h08;
  localparam logic [7:0] US_PF      = 8'h01;

  // UART control one bits
  localparam logic [7:0] FC_M  = 8'h10;
  localparam logic [7:0] FC_PE = 8'h02;
  localparam logic [7:0] FC_PT = 8'h01;

  localparam logic [7:0]       BRK_INFINITE = 8'hFF;
  localparam logic [7:0]       BRK_CHARS    = 8'd10;
  localparam logic [15:0]      BLEN_INF     = 16'hFFFF;
  localparam logic [DIV_W-1:0] DIV_SAT      = 14'h3FFF;

  localparam logic [7:0] CBITS_7    = 8'd7;
  localparam logic [7:0] CBITS_8    = 8'd8;
  localparam logic [7:0] PAR_ODD    = 8'd1;
  localparam logic [7:0] PAR_EVEN   = 8'd2;
  localparam logic [7:0] PAR_MARK   = 8'd3;
  localparam logic [7:0] PAR_SPACE  = 8'd4;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // item transfer this cycle
    logic div_start;  // launch baud divide
    logic commit;     // apply state update, load result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_coding;  // offered item is set_coding
    logic div_busy;
  } ctl_sts_t;

endpackage

@@ src/usbb_if.sv @@
// ----------------------------------------------------------------------------
// usbb_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface usbb_item_if;
  import usbb_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [7:0]       data_byte;
  logic             last_byte;
  logic [7:0]       uart_status;
  logic [15:0]      break_length;
  logic [31:0]      baud_rate;
  logic [7:0]       char_bits;
  logic [7:0]       parity_kind;

  modport source (
    output valid, cmd, data_byte, last_byte, uart_status, break_length,
           baud_rate, char_bits, parity_kind,
    input  ready
  );
  modport sink (
    input  valid, cmd, data_byte, last_byte, uart_status, break_length,
           baud_rate, char_bits, parity_kind,
    output ready
  );
endinterface

interface usbb_result_if;
  import usbb_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   tx_action;
  logic [7:0]         tx_byte;
  logic               load_busy;
  logic               rx_write;
  logic [RXIDX_W-1:0] rx_index;
  logic [RXCNT_W-1:0] rx_count;
  logic [7:0]         serial_state;
  logic [DIV_W-1:0]   baud_divider;
  logic [7:0]         frame_control;
  logic               stick_bit;
  logic               tx_irq_enable;

  modport source (
    output valid, tx_action, tx_byte, load_busy, rx_write, rx_index, rx_count,
           serial_state, baud_divider, frame_control, stick_bit, tx_irq_enable,
    input  ready
  );
  modport sink (
    input  valid, tx_action, tx_byte, load_busy, rx_write, rx_index, rx_count,
           serial_state, baud_divider, frame_control, stick_bit, tx_irq_enable,
    output ready
  );
endinterface

@@ src/usb_serial_bridge_buffer_control.sv @@
// ----------------------------------------------------------------------------
// usb_serial_bridge_buffer_control
// Transmit/receive buffer and line control between a USB serial endpoint
// and a UART, one command per item.
// ----------------------------------------------------------------------------
// Usage:
//   item   : command transfers (cmd plus its operand fields), valid/ready.
//   result : one result transfer per command, valid/ready. Fields that the
//            command does not use read as zero; tx_irq_enable always shows
//            the transmit interrupt enable after the command.
// Sequence:
//   Every command except set_coding goes from the transfer to the execute
//   state, which updates the state and loads the result register.
//   set_coding adds the restoring baud divider, one quotient bit per cycle,
//   between the transfer and the execute state.
//   item.ready is high only while the sequencer is idle.
// Stall:
//   A result waits in its output register while the next command is taken;
//   that command then holds in execute until the result register is free.
// Reset:
//   rst (synchronous) clears pointers, counts, break and interrupt state;
//   sticky status comes up with the change bit set. item.ready is low while
//   rst is high. The transmit store has no reset and holds nothing valid
//   until a block has been loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_serial_bridge_buffer_control #(
  parameter int TX_DEPTH     = usbb_pkg::DEF_TX_DEPTH,
  parameter int RX_DEPTH     = usbb_pkg::DEF_RX_DEPTH,
  parameter int BUS_CLOCK_HZ = usbb_pkg::DEF_BUS_CLOCK_HZ
) (
  input  logic          clk,
  input  logic          rst,
  usbb_item_if.sink     item,
  usbb_result_if.source result
);
  import usbb_pkg::*;

  ctl_cmd_t ctl;   // sequencer commands
  ctl_sts_t sts;   // datapath status

  // Sequencer: idle / divide / execute, owns the result valid flag.
  usbb_controller u_ctl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .ctl          (ctl),
    .sts          (sts)
  );

  // Datapath: transmit store, pointers, status, divider, result payload.
  usbb_datapath #(
    .TX_DEPTH     (TX_DEPTH),
    .RX_DEPTH     (RX_DEPTH),
    .BUS_CLOCK_HZ (BUS_CLOCK_HZ)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (item.cmd),
    .data_byte     (item.data_byte),
    .last_byte     (item.last_byte),
    .uart_status   (item.uart_status),
    .break_length  (item.break_length),
    .baud_rate     (item.baud_rate),
    .char_bits     (item.char_bits),
    .parity_kind   (item.parity_kind),
    .tx_action     (result.tx_action),
    .tx_byte       (result.tx_byte),
    .load_busy     (result.load_busy),
    .rx_write      (result.rx_write),
    .rx_index      (result.rx_index),
    .rx_count      (result.rx_count),
    .serial_state  (result.serial_state),
    .baud_divider  (result.baud_divider),
    .frame_control (result.frame_control),
    .stick_bit     (result.stick_bit),
    .tx_irq_enable (result.tx_irq_enable)
  );

endmodule

@@ src/usbb_divider.sv @@
// ----------------------------------------------------------------------------
// usbb_divider
// Restoring divider: (BUS_CLOCK_HZ / 16) / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usbb_divider #(
  parameter int BUS_CLOCK_HZ = usbb_pkg::DEF_BUS_CLOCK_HZ
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                divisor,
  output logic                       busy,
  output logic [usbb_pkg::DIV_W-1:0] quotient
);
  import usbb_pkg::*;

  localparam int DIVIDEND = BUS_CLOCK_HZ / 16;
  localparam int DW       = $clog2(DIVIDEND + 1);
  localparam int CW       = $clog2(DW + 1);

  logic [CW-1:0]    count;
  logic [DW-1:0]    dvd;
  logic [DW-1:0]    rem;
  logic [31:0]      dsr;
  logic [DW:0]      trial;
  logic             fits;

  assign busy  = (count != '0);
  assign trial = {rem, dvd[DW-1]};
  assign fits  = (33'(trial) >= 33'(dsr));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(DW);
    end else if (busy) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= DW'(DIVIDEND);
      rem      <= '0;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DW-2:0], 1'b0};
      rem      <= fits ? DW'(trial - (DW+1)'(dsr)) : DW'(trial);
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

@@ src/usbb_datapath.sv @@
// ----------------------------------------------------------------------------
// usbb_datapath
// Buffer pointers, status registers, transmit store and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usbb_datapath #(
  parameter int TX_DEPTH     = usbb_pkg::DEF_TX_DEPTH,
  parameter int RX_DEPTH     = usbb_pkg::DEF_RX_DEPTH,
  parameter int BUS_CLOCK_HZ = usbb_pkg::DEF_BUS_CLOCK_HZ
) (
  input  logic                         clk,
  input  logic                         rst,
  input  usbb_pkg::ctl_cmd_t           ctl,
  output usbb_pkg::ctl_sts_t           sts,
  input  logic [usbb_pkg::CMD_W-1:0]   cmd,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  input  logic [7:0]                   uart_status,
  input  logic [15:0]                  break_length,
  input  logic [31:0]                  baud_rate,
  input  logic [7:0]                   char_bits,
  input  logic [7:0]                   parity_kind,
  output logic [usbb_pkg::ACT_W-1:0]   tx_action,
  output logic [7:0]                   tx_byte,
  output logic                         load_busy,
  output logic                         rx_write,
  output logic [usbb_pkg::RXIDX_W-1:0] rx_index,
  output logic [usbb_pkg::RXCNT_W-1:0] rx_count,
  output logic [7:0]                   serial_state,
  output logic [usbb_pkg::DIV_W-1:0]   baud_divider,
  output logic [7:0]                   frame_control,
  output logic                         stick_bit,
  output logic                         tx_irq_enable
);
  import usbb_pkg::*;

  localparam int TC = $clog2(TX_DEPTH + 1);
  localparam int TI = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RC = $clog2(RX_DEPTH + 1);
  localparam int RW = (RC > RXCNT_W) ? RC : RXCNT_W;

  // captured item
  cmd_t        c_cmd;
  logic [7:0]  c_data;
  logic        c_last;
  logic [7:0]  c_ustat;
  logic [15:0] c_blen;
  logic        c_baud_zero;
  logic [7:0]  c_cbits;
  logic [7:0]  c_par;

  // block state
  logic [TC-1:0] tx_head, tx_head_next;
  logic [TC-1:0] tx_count, tx_count_next;
  logic [TC-1:0] load_index, load_index_next;
  logic          load_rejecting, load_rejecting_next;
  logic [RC-1:0] rx_fill, rx_fill_next;
  logic [7:0]    break_remaining, break_remaining_next;
  logic [7:0]    sticky_status, sticky_status_next;
  logic [7:0]    reported_status, reported_status_next;
  logic          tx_irq_on, tx_irq_on_next;

  logic [7:0]    tx_store [2**TI];
  logic [7:0]    rd_data;
  logic          wr_en;

  logic               div_busy;
  logic [DIV_W-1:0]   quotient;
  logic [RW-1:0]      fill_w;

  // result next values
  tx_action_t         r_action;
  logic [7:0]         r_byte;
  logic               r_busy;
  logic               r_write;
  logic [RXIDX_W-1:0] r_index;
  logic [RXCNT_W-1:0] r_count;
  logic [7:0]         r_state;
  logic [DIV_W-1:0]   r_div;
  logic [7:0]         r_fc;
  logic               r_stick;

  usbb_divider #(.BUS_CLOCK_HZ(BUS_CLOCK_HZ)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .divisor  (baud_rate),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign sts.item_coding = (cmd == CMD_SET_CODING);
  assign sts.div_busy    = div_busy;
  assign fill_w          = RW'(rx_fill);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      c_cmd       <= cmd_t'(cmd);
      c_data      <= data_byte;
      c_last      <= last_byte;
      c_ustat     <= uart_status;
      c_blen      <= break_length;
      c_baud_zero <= (baud_rate == 32'd0);
      c_cbits     <= char_bits;
      c_par       <= parity_kind;
    end
  end

  // transmit store, registered read at the head pointer
  always_ff @(posedge clk) begin
    if (ctl.commit && wr_en) begin
      tx_store[load_index[TI-1:0]] <= c_data;
    end
    rd_data <= tx_store[tx_head[TI-1:0]];
  end

  always_comb begin
    tx_head_next         = tx_head;
    tx_count_next        = tx_count;
    load_index_next      = load_index;
    load_rejecting_next  = load_rejecting;
    rx_fill_next         = rx_fill;
    break_remaining_next = break_remaining;
    sticky_status_next   = sticky_status;
    reported_status_next = reported_status;
    tx_irq_on_next       = tx_irq_on;
    wr_en    = 1'b0;
    r_action = ACT_NONE;
    r_byte   = '0;
    r_busy   = 1'b0;
    r_write  = 1'b0;
    r_index  = '0;
    r_count  = '0;
    r_state  = '0;
    r_div    = '0;
    r_fc     = '0;
    r_stick  = 1'b0;

    case (c_cmd)
      CMD_TX_LOAD: begin
        // busy check happens on the first byte of a block only
        if (load_index == '0 && !load_rejecting && tx_count != '0) begin
          load_rejecting_next = 1'b1;
        end
        if (load_rejecting_next) begin
          r_busy = 1'b1;
          if (c_last) begin
            load_rejecting_next = 1'b0;
          end
        end else begin
          if (load_index < TC'(TX_DEPTH)) begin
            wr_en           = 1'b1;
            load_index_next = load_index + TC'(1);
          end
          if (c_last) begin
            tx_head_next    = '0;
            tx_count_next   = load_index_next;
            load_index_next = '0;
            tx_irq_on_next  = 1'b1;
          end
        end
      end
      CMD_TX_READY: begin
        if (tx_count != '0 && tx_head < TC'(TX_DEPTH)) begin
          r_action     = ACT_SEND_BYTE;
          r_byte       = rd_data;
          tx_head_next = tx_head + TC'(1);
          if (tx_head_next >= tx_count) begin
            tx_count_next = '0;
          end
        end else if (break_remaining != '0) begin
          r_action = ACT_BREAK;
          if (break_remaining != BRK_INFINITE) begin
            break_remaining_next = break_remaining - 8'd1;
          end
        end else begin
          tx_count_next  = '0;
          tx_irq_on_next = 1'b0;
          r_action       = ACT_IRQ_OFF;
        end
      end
      CMD_RX_BYTE: begin
        if (rx_fill >= RC'(RX_DEPTH)) begin
          sticky_status_next = sticky_status | US_OR;
        end else begin
          r_write      = 1'b1;
          r_index      = fill_w[RXIDX_W-1:0];
          rx_fill_next = rx_fill + RC'(1);
        end
      end
      CMD_RX_SWAP: begin
        r_count      = (fill_w > RW'(31)) ? RXCNT_W'(31) : fill_w[RXCNT_W-1:0];
        rx_fill_next = '0;
      end
      CMD_LINE_ERROR: begin
        sticky_status_next = sticky_status | c_ustat;
      end
      CMD_GET_STATE: begin
        r_state = ST_BASE;
        if ((sticky_status & US_FE) != '0) r_state = r_state | ST_FRAMING;
        if ((sticky_status & US_OR) != '0) r_state = r_state | ST_OVERRUN;
        if ((sticky_status & US_PF) != '0) r_state = r_state | ST_PARITY;
        if (reported_status != sticky_status) begin
          reported_status_next = sticky_status;
          r_state              = r_state | ST_CHANGE;
        end
        sticky_status_next = '0;
      end
      CMD_SEND_BREAK: begin
        if (c_blen == BLEN_INF) begin
          break_remaining_next = BRK_INFINITE;
        end else if (c_blen == 16'd0) begin
          break_remaining_next = '0;
        end else begin
          break_remaining_next = BRK_CHARS;
        end
      end
      CMD_SET_CODING: begin
        r_div = c_baud_zero ? DIV_SAT : quotient;
        case (c_cbits)
          CBITS_7: begin
            case (c_par)
              PAR_ODD:  r_fc = FC_PE | FC_PT;
              PAR_EVEN: r_fc = FC_PE;
              default:  r_fc = '0;
            endcase
          end
          CBITS_8: begin
            case (c_par)
              PAR_ODD:   r_fc = FC_M | FC_PE | FC_PT;
              PAR_EVEN:  r_fc = FC_M | FC_PE;
              PAR_MARK: begin
                r_fc    = FC_M;
                r_stick = 1'b1;
              end
              PAR_SPACE: r_fc = FC_M;
              default:   r_fc = '0;
            endcase
          end
          default: r_fc = '0;
        endcase
        // coding change flushes buffers, break and interrupt state; sticky status resets to change
        sticky_status_next   = ST_CHANGE;
        break_remaining_next = '0;
        rx_fill_next         = '0;
        tx_count_next        = '0;
        tx_head_next         = '0;
        load_index_next      = '0;
        load_rejecting_next  = 1'b0;
        tx_irq_on_next       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head         <= '0;
      tx_count        <= '0;
      load_index      <= '0;
      load_rejecting  <= 1'b0;
      rx_fill         <= '0;
      break_remaining <= '0;
      sticky_status   <= ST_CHANGE;
      reported_status <= '0;
      tx_irq_on       <= 1'b0;
    end else if (ctl.commit) begin
      tx_head         <= tx_head_next;
      tx_count        <= tx_count_next;
      load_index      <= load_index_next;
      load_rejecting  <= load_rejecting_next;
      rx_fill         <= rx_fill_next;
      break_remaining <= break_remaining_next;
      sticky_status   <= sticky_status_next;
      reported_status <= reported_status_next;
      tx_irq_on       <= tx_irq_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      tx_action     <= r_action;
      tx_byte       <= r_byte;
      load_busy     <= r_busy;
      rx_write      <= r_write;
      rx_index      <= r_index;
      rx_count      <= r_count;
      serial_state  <= r_state;
      baud_divider  <= r_div;
      frame_control <= r_fc;
      stick_bit     <= r_stick;
      tx_irq_enable <= tx_irq_on_next;
    end
  end

endmodule

@@ src/usbb_controller.sv @@
// ----------------------------------------------------------------------------
// usbb_controller
// Sequencer: accept, optional baud divide, execute into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usbb_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  output logic               result_valid,
  input  logic               result_ready,
  output usbb_pkg::ctl_cmd_t ctl,
  input  usbb_pkg::ctl_sts_t sts
);
  import usbb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  // no transfer is taken while reset is high
  assign item_ready    = (state == ST_IDLE) && !rst;
  assign out_free      = !result_valid || result_ready;
  assign ctl.capture   = item_valid && item_ready;
  assign ctl.div_start = ctl.capture && sts.item_coding;
  assign ctl.commit    = (state == ST_EXEC) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctl.capture) begin
          state_next = sts.item_coding ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/usbb_checker.sv @@
// ----------------------------------------------------------------------------
// usbb_checker
// Port-level checks of the bridge buffer control, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usbb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [usbb_pkg::ACT_W-1:0] tx_action,
  input logic                       load_busy,
  input logic                       rx_write,
  input logic                       tx_irq_enable
);
  import usbb_pkg::*;

  // no result survives reset
  `USBB_ASSERT_NXT_ALWAYS(a_reset_no_result, clk, rst, !result_valid)

  // a stalled result stays offered
  `USBB_ASSERT_NXT(a_stall_hold, clk, rst, result_valid && !result_ready, result_valid)

  // bytes are only pending while the transmit interrupt is on
  `USBB_ASSERT_IMP(a_send_irq_on, clk, rst, result_valid && tx_action == ACT_SEND_BYTE, tx_irq_enable)

  // the idle-transmitter answer always turns the interrupt off
  `USBB_ASSERT_IMP(a_off_irq_off, clk, rst, result_valid && tx_action == ACT_IRQ_OFF, !tx_irq_enable)

  // receive strobe comes from an rx_byte command only
  `USBB_ASSERT_IMP(a_rx_alone, clk, rst, result_valid && rx_write, tx_action == ACT_NONE && !load_busy)

endmodule

bind usb_serial_bridge_buffer_control usbb_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .tx_action     (result.tx_action),
  .load_busy     (result.load_busy),
  .rx_write      (result.rx_write),
  .tx_irq_enable (result.tx_irq_enable)
);

@@ sim/tb_usb_serial_bridge_buffer_control.sv @@
// ----------------------------------------------------------------------------
// tb_usb_serial_bridge_buffer_control
// Self-checking bench for the USB serial bridge buffer control. A clocked
// driver feeds command transfers from a backlog. A clocked monitor takes
// result transfers and checks each one against a cycle-free model of the
// buffers and the line control. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_usb_serial_bridge_buffer_control;
  import usbb_pkg::*;

  localparam int TX_SLOTS       = DEF_TX_DEPTH;
  localparam int RX_SLOTS       = DEF_RX_DEPTH;
  localparam int ITEM_GOAL      = 1600;
  // Quiet cycles allowed before the run is declared hung. The worst honest
  // gap is a long sender gap, a set_coding divide and a long result stall.
  localparam int WATCHDOG_LIMIT = 2000;
  // set_coding is the slowest command.
  localparam int DRAIN_CYCLES   = 30;

  // One command transfer, all operand fields.
  typedef struct {
    cmd_t        cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  uart_status;
    logic [15:0] break_length;
    logic [31:0] baud_rate;
    logic [7:0]  char_bits;
    logic [7:0]  parity_kind;
  } bridge_cmd_t;

  // One result transfer.
  typedef struct {
    tx_action_t          tx_action;
    logic [7:0]          tx_byte;
    logic                load_busy;
    logic                rx_write;
    logic [RXIDX_W-1:0]  rx_index;
    logic [RXCNT_W-1:0]  rx_count;
    logic [7:0]          serial_state;
    logic [DIV_W-1:0]    baud_divider;
    logic [7:0]          frame_control;
    logic                stick_bit;
    logic                tx_irq_enable;
  } bridge_res_t;

  logic clk;
  logic rst;

  usbb_item_if   item_ch ();
  usbb_result_if result_ch ();

  usb_serial_bridge_buffer_control u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  bridge_cmd_t cmd_backlog[$];    // commands not yet offered
  bridge_res_t owed_results[$];   // predicted results, oldest first
  bridge_cmd_t offered;           // command currently on the item channel
  int          errors = 0;
  int          idle_left = 0;     // sender gap still to serve
  int          stall_left = 0;    // receiver stall still to serve
  int          calm_left = 0;     // items left in a stretch with no idling
  int          quiet_cycles = 0;

  // Shadow state of the bridge.
  logic [7:0]  tx_mem [TX_SLOTS];
  int unsigned tx_rd;
  int unsigned tx_len;
  int unsigned load_pos;
  bit          load_refusing;
  int unsigned rx_level;
  logic [7:0]  brk_left;
  logic [7:0]  sticky_st;
  logic [7:0]  reported_st;
  bit          irq_on;

  // Most gaps short, a few long; none inside a calm stretch.
  function automatic int pick_idle();
    int r;
    if (calm_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 50);
  endfunction

  // Command with every operand randomized; callers override what matters.
  function automatic bridge_cmd_t fresh_cmd(cmd_t c);
    bridge_cmd_t x;
    x.cmd         = c;
    x.data_byte   = 8'($urandom);
    x.last_byte   = 1'($urandom_range(0, 1));
    x.uart_status = 8'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        x.break_length = 16'd0;
      end
      1: begin
        x.break_length = BLEN_INF;
      end
      default: begin
        x.break_length = 16'($urandom);
      end
    endcase
    case ($urandom_range(0, 9))
      0: begin
        x.baud_rate = 32'd0;
      end
      1, 2: begin
        x.baud_rate = $urandom;
      end
      3, 4: begin
        x.baud_rate = $urandom_range(1, 2000);
      end
      default: begin
        x.baud_rate = $urandom_range(300, 3000000);
      end
    endcase
    x.char_bits   = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                    ($urandom_range(0, 1) ? CBITS_8 : CBITS_7);
    x.parity_kind = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                    8'($urandom_range(0, 5));
    return x;
  endfunction

  // Advance the shadow state by one command and return the result it owes.
  function automatic bridge_res_t predict_response(bridge_cmd_t c);
    bridge_res_t r;
    logic [7:0]  st;
    logic [31:0] quo;
    r.tx_action     = ACT_NONE;
    r.tx_byte       = '0;
    r.load_busy     = 1'b0;
    r.rx_write      = 1'b0;
    r.rx_index      = '0;
    r.rx_count      = '0;
    r.serial_state  = '0;
    r.baud_divider  = '0;
    r.frame_control = '0;
    r.stick_bit     = 1'b0;
    case (c.cmd)
      CMD_TX_LOAD: begin
        // Busy is decided on the first byte and holds to the block's end.
        if (load_pos == 0 && !load_refusing && tx_len > 0) load_refusing = 1'b1;
        if (load_refusing) begin
          r.load_busy = 1'b1;
          if (c.last_byte) load_refusing = 1'b0;
        end else begin
          if (load_pos < TX_SLOTS) begin
            tx_mem[load_pos] = c.data_byte;
            load_pos++;
          end
          if (c.last_byte) begin
            tx_rd    = 0;
            tx_len   = load_pos;
            load_pos = 0;
            irq_on   = 1'b1;
          end
        end
      end
      CMD_TX_READY: begin
        if (tx_len > 0 && tx_rd < TX_SLOTS) begin
          r.tx_action = ACT_SEND_BYTE;
          r.tx_byte   = tx_mem[tx_rd];
          tx_rd++;
          if (tx_rd >= tx_len) tx_len = 0;
        end else if (brk_left != 0) begin
          r.tx_action = ACT_BREAK;
          if (brk_left != BRK_INFINITE) brk_left--;
        end else begin
          tx_len      = 0;
          irq_on      = 1'b0;
          r.tx_action = ACT_IRQ_OFF;
        end
      end
      CMD_RX_BYTE: begin
        if (rx_level >= RX_SLOTS) begin
          sticky_st |= US_OR;
        end else begin
          r.rx_write = 1'b1;
          r.rx_index = RXIDX_W'(rx_level);
          rx_level++;
        end
      end
      CMD_RX_SWAP: begin
        r.rx_count = (rx_level > 31) ? 5'd31 : RXCNT_W'(rx_level);
        rx_level   = 0;
      end
      CMD_LINE_ERROR: begin
        sticky_st |= c.uart_status;
      end
      CMD_GET_STATE: begin
        st = ST_BASE;
        if ((sticky_st & US_FE) != 0) st |= ST_FRAMING;
        if ((sticky_st & US_OR) != 0) st |= ST_OVERRUN;
        if ((sticky_st & US_PF) != 0) st |= ST_PARITY;
        if (reported_st != sticky_st) begin
          reported_st = sticky_st;
          st |= ST_CHANGE;
        end
        sticky_st      = 8'h00;
        r.serial_state = st;
      end
      CMD_SEND_BREAK: begin
        if (c.break_length == BLEN_INF) brk_left = BRK_INFINITE;
        else if (c.break_length == 16'd0) brk_left = 8'd0;
        else brk_left = BRK_CHARS;
      end
      default: begin
        // set_coding: divider, frame control, then a full line reset.
        if (c.baud_rate == 32'd0) begin
          r.baud_divider = DIV_SAT;
        end else begin
          quo            = 32'(DEF_BUS_CLOCK_HZ / 16) / c.baud_rate;
          r.baud_divider = quo[DIV_W-1:0];
        end
        if (c.char_bits == CBITS_7) begin
          if (c.parity_kind == PAR_ODD) r.frame_control = FC_PE | FC_PT;
          else if (c.parity_kind == PAR_EVEN) r.frame_control = FC_PE;
        end else if (c.char_bits == CBITS_8) begin
          if (c.parity_kind == PAR_ODD) begin
            r.frame_control = FC_M | FC_PE | FC_PT;
          end else if (c.parity_kind == PAR_EVEN) begin
            r.frame_control = FC_M | FC_PE;
          end else if (c.parity_kind == PAR_MARK) begin
            r.frame_control = FC_M;
            r.stick_bit     = 1'b1;
          end else if (c.parity_kind == PAR_SPACE) begin
            r.frame_control = FC_M;
          end
        end
        sticky_st     = ST_CHANGE;
        brk_left      = 8'd0;
        rx_level      = 0;
        tx_len        = 0;
        tx_rd         = 0;
        load_pos      = 0;
        load_refusing = 1'b0;
        irq_on        = 1'b0;
      end
    endcase
    r.tx_irq_enable = irq_on;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers backlog commands, predicts on every item transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      tx_rd         = 0;
      tx_len        = 0;
      load_pos      = 0;
      load_refusing = 1'b0;
      rx_level      = 0;
      brk_left      = 8'd0;
      sticky_st     = ST_CHANGE;
      reported_st   = 8'h00;
      irq_on        = 1'b0;
      idle_left     = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        owed_results.push_back(predict_response(offered));
      end
      // The channel is free once nothing is offered or the offer transferred.
      if (!item_ch.valid || item_ch.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          item_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          offered = cmd_backlog.pop_front();
          item_ch.cmd          <= offered.cmd;
          item_ch.data_byte    <= offered.data_byte;
          item_ch.last_byte    <= offered.last_byte;
          item_ch.uart_status  <= offered.uart_status;
          item_ch.break_length <= offered.break_length;
          item_ch.baud_rate    <= offered.baud_rate;
          item_ch.char_bits    <= offered.char_bits;
          item_ch.parity_kind  <= offered.parity_kind;
          item_ch.valid        <= 1'b1;
          if (calm_left > 0) calm_left--;
          else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(20, 60);
          idle_left = pick_idle();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure, field-by-field check of each result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bridge_res_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with no prediction pending");
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("tx_action",     want.tx_action,     result_ch.tx_action);
          check_field("tx_byte",       want.tx_byte,       result_ch.tx_byte);
          check_field("load_busy",     want.load_busy,     result_ch.load_busy);
          check_field("rx_write",      want.rx_write,      result_ch.rx_write);
          check_field("rx_index",      want.rx_index,      result_ch.rx_index);
          check_field("rx_count",      want.rx_count,      result_ch.rx_count);
          check_field("serial_state",  want.serial_state,  result_ch.serial_state);
          check_field("baud_divider",  want.baud_divider,  result_ch.baud_divider);
          check_field("frame_control", want.frame_control, result_ch.frame_control);
          check_field("stick_bit",     want.stick_bit,     result_ch.stick_bit);
          check_field("tx_irq_enable", want.tx_irq_enable, result_ch.tx_irq_enable);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_idle();
      end
    end
  end

  // Watchdog: no transfer on either channel for too long means a hang.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((item_ch.valid && item_ch.ready) ||
                 (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    bridge_cmd_t x;
    int          n;
    int          len;
    int          scen;

    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.cmd          = CMD_GET_STATE;
    item_ch.data_byte    = 8'h00;
    item_ch.last_byte    = 1'b0;
    item_ch.uart_status  = 8'h00;
    item_ch.break_length = 16'h0000;
    item_ch.baud_rate    = 32'h0;
    item_ch.char_bits    = 8'h00;
    item_ch.parity_kind  = 8'h00;
    result_ch.ready      = 1'b0;

    // Directed: reset status, idle tx_ready, a short block, a busy block,
    // drain, receive, sticky status, all break kinds, coding extremes.
    cmd_backlog.push_back(fresh_cmd(CMD_GET_STATE));
    cmd_backlog.push_back(fresh_cmd(CMD_TX_READY));
    x = fresh_cmd(CMD_TX_LOAD); x.data_byte = 8'hFF; x.last_byte = 1'b0;
    cmd_backlog.push_back(x);
    x = fresh_cmd(CMD_TX_LOAD); x.data_byte = 8'h00; x.last_byte = 1'b1;
    cmd_backlog.push_back(x);
    x = fresh_cmd(CMD_TX_LOAD); x.data_byte = 8'hA5; x.last_byte = 1'b1;
    cmd_backlog.push_back(x);
    repeat (3) cmd_backlog.push_back(fresh_cmd(CMD_TX_READY));
    repeat (2) cmd_backlog.push_back(fresh_cmd(CMD_RX_BYTE));
    cmd_backlog.push_back(fresh_cmd(CMD_RX_SWAP));
    x = fresh_cmd(CMD_LINE_ERROR); x.uart_status = 8'hFF;
    cmd_backlog.push_back(x);
    repeat (2) cmd_backlog.push_back(fresh_cmd(CMD_GET_STATE));
    x = fresh_cmd(CMD_SEND_BREAK); x.break_length = BLEN_INF;
    cmd_backlog.push_back(x);
    cmd_backlog.push_back(fresh_cmd(CMD_TX_READY));
    x = fresh_cmd(CMD_SEND_BREAK); x.break_length = 16'd5;
    cmd_backlog.push_back(x);
    cmd_backlog.push_back(fresh_cmd(CMD_TX_READY));
    x = fresh_cmd(CMD_SEND_BREAK); x.break_length = 16'd0;
    cmd_backlog.push_back(x);
    cmd_backlog.push_back(fresh_cmd(CMD_TX_READY));
    x = fresh_cmd(CMD_SET_CODING);
    x.baud_rate = 32'd0; x.char_bits = CBITS_8; x.parity_kind = PAR_MARK;
    cmd_backlog.push_back(x);
    x = fresh_cmd(CMD_SET_CODING);
    x.baud_rate = 32'hFFFF_FFFF; x.char_bits = CBITS_7; x.parity_kind = PAR_ODD;
    cmd_backlog.push_back(x);
    x = fresh_cmd(CMD_SET_CODING);
    x.baud_rate = 32'd1; x.char_bits = CBITS_8; x.parity_kind = PAR_SPACE;
    cmd_backlog.push_back(x);
    x = fresh_cmd(CMD_SET_CODING);
    x.baud_rate = 32'd115200; x.char_bits = CBITS_7; x.parity_kind = PAR_MARK;
    cmd_backlog.push_back(x);
    x = fresh_cmd(CMD_SET_CODING);
    x.baud_rate = 32'd9600; x.char_bits = 8'd5; x.parity_kind = PAR_EVEN;
    cmd_backlog.push_back(x);

    // Random: mostly well-formed sequences with random content.
    n = 0;
    while (n < ITEM_GOAL) begin
      scen = $urandom_range(0, 99);
      if (scen < 25) begin
        // Transmit block; sometimes too long, sometimes cut by set_coding.
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 24) :
                                            $urandom_range(1, TX_SLOTS);
        for (int i = 0; i < len; i++) begin
          if (i == len / 2 && i > 0 && $urandom_range(0, 24) == 0) begin
            cmd_backlog.push_back(fresh_cmd(CMD_SET_CODING));
            n++;
            break;
          end
          x = fresh_cmd(CMD_TX_LOAD);
          x.last_byte = (i == len - 1);
          cmd_backlog.push_back(x);
          n++;
        end
      end else if (scen < 45) begin
        len = $urandom_range(1, 18);
        repeat (len) cmd_backlog.push_back(fresh_cmd(CMD_TX_READY));
        n += len;
      end else if (scen < 57) begin
        cmd_backlog.push_back(fresh_cmd(CMD_SEND_BREAK));
        len = $urandom_range(1, 14);
        repeat (len) cmd_backlog.push_back(fresh_cmd(CMD_TX_READY));
        n += len + 1;
      end else if (scen < 72) begin
        // Receive burst, often past the buffer depth to hit overrun.
        len = $urandom_range(1, RX_SLOTS + 4);
        repeat (len) cmd_backlog.push_back(fresh_cmd(CMD_RX_BYTE));
        n += len;
        if ($urandom_range(0, 4) != 0) begin
          cmd_backlog.push_back(fresh_cmd(CMD_RX_SWAP));
          n++;
        end
      end else if (scen < 82) begin
        cmd_backlog.push_back(fresh_cmd(CMD_LINE_ERROR));
        cmd_backlog.push_back(fresh_cmd(CMD_GET_STATE));
        n += 2;
      end else if (scen < 87) begin
        cmd_backlog.push_back(fresh_cmd(CMD_SET_CODING));
        n++;
      end else begin
        // Noise: any command, any operands.
        cmd_backlog.push_back(fresh_cmd(cmd_t'($urandom_range(0, 7))));
        n++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to transfer and every result to come back.
    while (cmd_backlog.size() > 0 || item_ch.valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (owed_results.size() > 0) begin
      $error("%0d predicted results never arrived", owed_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/usbb_pkg.sv
src/usbb_if.sv
src/usbb_divider.sv
src/usbb_datapath.sv
src/usbb_controller.sv
src/usb_serial_bridge_buffer_control.sv
src/usbb_checker.sv
sim/tb_usb_serial_bridge_buffer_control.sv
